>>> design/fbd_pkg.sv
package fbd_pkg;
   localparam int ClockWidth    = 28;
   localparam int BaudWidth     = 22;
   localparam int DivisorWidth  = 27;
   localparam int NibbleWidth   = 4;
   localparam int ErrorWidth    = 28;
   localparam int FractionLimit = 15;
   // f*m fits in 32 bits; divisor step*baud fits in 32 bits as well
   localparam int NumWidth      = 32;
   localparam int DenWidth      = 32;
   localparam int CountWidth    = 6;
   localparam int MinDivisor    = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV1,
      ST_DIV2,
      ST_EVAL,
      ST_NEXT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctrl_type;
endpackage

>>> design/fbd_divider.sv
module fbd_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  fbd_pkg::div_ctrl_type         ctrl_in,
   input  logic [fbd_pkg::NumWidth-1:0]  numer,
   input  logic [fbd_pkg::DenWidth-1:0]  denom,
   output fbd_pkg::div_ctrl_type         ctrl_out,
   output logic [fbd_pkg::NumWidth-1:0]  quot
);
   import fbd_pkg::*;

   logic [NumWidth-1:0]   quot_ff, quot_in;
   logic [DenWidth:0]     rem_ff, rem_in;
   logic [DenWidth-1:0]   den_ff, den_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [DenWidth:0]     trial;

   // one quotient bit per cycle, restoring
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (ctrl_in.start) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CountWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff[DenWidth-1:0], quot_ff[NumWidth-1]};
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CountWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot           = quot_ff;
   assign ctrl_out.start = 1'b0;
   assign ctrl_out.busy  = busy_ff;
   assign ctrl_out.done  = done_ff;
endmodule

>>> design/fractional_baud_divider_search.sv
// Search: 225 (mul, add) pairs, each running the divisor division and, when the
// divisor is at least 2, the rate division; the best result is then posted, and a
// zero wanted rate skips the search and goes straight to posting the result.
// Throughput: one transaction at a time, set by the shared bit-serial divider
// (32 quotient bits, one per cycle).
// Reset: synchronous, active high; clears the sequencer and output valid.
module fractional_baud_divider_search #(
   parameter int FRACTION_LIMIT = fbd_pkg::FractionLimit
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [fbd_pkg::ClockWidth-1:0]    req_clock_hz,
   input  logic [fbd_pkg::BaudWidth-1:0]     req_wanted_baud,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [fbd_pkg::DivisorWidth-1:0]  rsp_divisor,
   output logic [fbd_pkg::NibbleWidth-1:0]   rsp_add_value,
   output logic [fbd_pkg::NibbleWidth-1:0]   rsp_mul_value,
   output logic [fbd_pkg::ErrorWidth-1:0]    rsp_rate_error
);
   import fbd_pkg::*;

   state_type state_ff, state_in;
   logic [ClockWidth-1:0]  f_ff, f_in;
   logic [BaudWidth-1:0]   baud_ff, baud_in;
   logic [NibbleWidth-1:0] m_ff, m_in, a_ff, a_in;
   logic [NumWidth-1:0]    num_ff, num_in, d_ff, d_in;
   logic [4:0]             step;
   logic                   have_ff, have_in, rv_ff, rv_in;
   logic [DivisorWidth-1:0] bd_ff, bd_in;
   logic [NibbleWidth-1:0] ba_ff, ba_in, bm_ff, bm_in;
   logic [ErrorWidth-1:0]  be_ff, be_in;
   logic [NumWidth-1:0]    err;
   div_ctrl_type           dctl, dstat;
   logic [NumWidth-1:0]    dnum, quot;
   logic [DenWidth-1:0]    dden;
   logic                   kick_ff, kick_in;

   assign step = 5'(m_ff) + 5'(a_ff);

   fbd_divider u_div (
      .clock(clock), .reset(reset), .ctrl_in(dctl), .numer(dnum), .denom(dden),
      .ctrl_out(dstat), .quot(quot)
   );

   always_comb begin
      state_in = state_ff;
      f_in = f_ff; baud_in = baud_ff; m_in = m_ff; a_in = a_ff;
      num_in = num_ff; d_in = d_ff; have_in = have_ff; rv_in = rv_ff;
      bd_in = bd_ff; ba_in = ba_ff; bm_in = bm_ff; be_in = be_ff;
      dctl = '0;
      // start the divisor division once the pair's operands are registered
      dctl.start = kick_ff;
      dnum = num_ff;
      dden = DenWidth'({step, 4'b0}) * DenWidth'(baud_ff);
      err  = (quot > NumWidth'(baud_ff)) ? quot - NumWidth'(baud_ff)
                                          : NumWidth'(baud_ff) - quot;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !rv_ff) begin
               f_in = req_clock_hz; baud_in = req_wanted_baud;
               m_in = NibbleWidth'(1); a_in = NibbleWidth'(1);
               num_in = NumWidth'(req_clock_hz);
               have_in = 1'b0;
               bd_in = '0; ba_in = '0; bm_in = '0; be_in = '0;
               state_in = (req_wanted_baud == '0) ? ST_DONE : ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (dstat.done) begin
               d_in = quot;
               if (quot < NumWidth'(MinDivisor)) begin
                  state_in = ST_NEXT;
               end else begin
                  dden = DenWidth'({step, 4'b0}) * quot;
                  dctl.start = 1'b1;
                  state_in = ST_DIV2;
               end
            end
         end
         ST_DIV2: begin
            if (dstat.done) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!have_ff || err < NumWidth'(be_ff)) begin
               have_in = 1'b1;
               be_in = ErrorWidth'(err);
               bd_in = DivisorWidth'(d_ff);
               ba_in = a_ff; bm_in = m_ff;
            end
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (a_ff == NibbleWidth'(FRACTION_LIMIT)) begin
               a_in = NibbleWidth'(1);
               if (m_ff == NibbleWidth'(FRACTION_LIMIT)) begin
                  state_in = ST_DONE;
               end else begin
                  m_in = m_ff + 1'b1;
                  num_in = num_ff + NumWidth'(f_ff);
                  state_in = ST_DIV1;
               end
            end else begin
               a_in = a_ff + 1'b1;
               state_in = ST_DIV1;
            end
         end
         ST_DONE: begin
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      kick_in = (state_in == ST_DIV1) && (state_ff != ST_DIV1);
   end

   always_ff @(posedge clock) begin
      f_ff <= f_in; baud_ff <= baud_in; m_ff <= m_in; a_ff <= a_in;
      num_ff <= num_in; d_ff <= d_in;
      bd_ff <= bd_in; ba_ff <= ba_in; bm_ff <= bm_in; be_ff <= be_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         have_ff  <= 1'b0;
         rv_ff    <= 1'b0;
         kick_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         have_ff  <= have_in;
         rv_ff    <= rv_in;
         kick_ff  <= kick_in;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE) || rv_ff;
   assign rsp_valid      = rv_ff;
   assign rsp_found      = have_ff;
   assign rsp_divisor    = bd_ff;
   assign rsp_add_value  = ba_ff;
   assign rsp_mul_value  = bm_ff;
   assign rsp_rate_error = be_ff;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_divisor))
      else $error("result changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_divisor == '0)
      else $error("divisor set without found");
endmodule

>>> tb/sv/fbd_checker.sv
module fbd_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [fbd_pkg::ClockWidth-1:0]    req_clock_hz,
   input  logic [fbd_pkg::BaudWidth-1:0]     req_wanted_baud,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_found,
   input  logic [fbd_pkg::DivisorWidth-1:0]  rsp_divisor,
   input  logic [fbd_pkg::NibbleWidth-1:0]   rsp_add_value,
   input  logic [fbd_pkg::NibbleWidth-1:0]   rsp_mul_value,
   input  logic [fbd_pkg::ErrorWidth-1:0]    rsp_rate_error,
   output int                                fail_count,
   output int                                pending_count
);
   import fbd_pkg::*;

   typedef struct {
      logic                     found;
      logic [DivisorWidth-1:0]  divisor;
      logic [NibbleWidth-1:0]   add_value;
      logic [NibbleWidth-1:0]   mul_value;
      logic [ErrorWidth-1:0]    rate_error;
   } divider_choice_type;

   divider_choice_type expected_choices[$];

   // Exhaustive search over (mul, add) in 64-bit arithmetic; first strict minimum wins.
   function automatic divider_choice_type search_divider(logic [ClockWidth-1:0] clk_hz,
                                                         logic [BaudWidth-1:0] baud_in);
      longint unsigned f, baud, num, step, d, rate, err, best_err;
      bit have;
      divider_choice_type best;
      f = clk_hz;
      baud = baud_in;
      have = 0;
      best_err = 0;
      best = '{1'b0, '0, '0, '0, '0};
      if (baud != 0) begin
         for (int m = 1; m <= FractionLimit; m++) begin
            num = f * m;
            for (int a = 1; a <= FractionLimit; a++) begin
               step = longint'(m + a) * 16;
               d = num / (step * baud);
               if (d < MinDivisor) continue;
               rate = num / (step * d);
               err = (rate > baud) ? rate - baud : baud - rate;
               if (!have || err < best_err) begin
                  have = 1;
                  best_err = err;
                  best.found = 1'b1;
                  best.divisor = d[DivisorWidth-1:0];
                  best.add_value = a[NibbleWidth-1:0];
                  best.mul_value = m[NibbleWidth-1:0];
                  best.rate_error = best_err[ErrorWidth-1:0];
               end
            end
         end
      end
      return best;
   endfunction

   always @(posedge clock) begin
      divider_choice_type want;
      if (reset) begin
         fail_count = 0;
         pending_count = 0;
      end else begin
         if (req_valid && !req_stall)
            expected_choices.push_back(search_divider(req_clock_hz, req_wanted_baud));
         if (rsp_valid && !rsp_stall) begin
            if (expected_choices.size() == 0) begin
               $display("%0t: unexpected transaction found=%0d div=%0d add=%0d mul=%0d err=%0d",
                        $time, rsp_found, rsp_divisor, rsp_add_value, rsp_mul_value,
                        rsp_rate_error);
               fail_count++;
            end else begin
               want = expected_choices.pop_front();
               if (rsp_found !== want.found) begin
                  $display("%0t: found expected %0d actual %0d", $time, want.found, rsp_found);
                  fail_count++;
               end
               if (rsp_divisor !== want.divisor) begin
                  $display("%0t: divisor expected %0d actual %0d", $time, want.divisor,
                           rsp_divisor);
                  fail_count++;
               end
               if (rsp_add_value !== want.add_value) begin
                  $display("%0t: add_value expected %0d actual %0d", $time, want.add_value,
                           rsp_add_value);
                  fail_count++;
               end
               if (rsp_mul_value !== want.mul_value) begin
                  $display("%0t: mul_value expected %0d actual %0d", $time, want.mul_value,
                           rsp_mul_value);
                  fail_count++;
               end
               if (rsp_rate_error !== want.rate_error) begin
                  $display("%0t: rate_error expected %0d actual %0d", $time, want.rate_error,
                           rsp_rate_error);
                  fail_count++;
               end
            end
         end
         pending_count = expected_choices.size();
      end
   end
endmodule

>>> tb/sv/tb_fractional_baud_divider_search.sv
module tb_fractional_baud_divider_search;
   import fbd_pkg::*;

   localparam int CycleLimit = 12000000;
   localparam int LongHold   = 20000;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_stall;
   logic [ClockWidth-1:0]    req_clock_hz = '0;
   logic [BaudWidth-1:0]     req_wanted_baud = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 0;
   logic                     rsp_found;
   logic [DivisorWidth-1:0]  rsp_divisor;
   logic [NibbleWidth-1:0]   rsp_add_value;
   logic [NibbleWidth-1:0]   rsp_mul_value;
   logic [ErrorWidth-1:0]    rsp_rate_error;
   int                       fail_count;
   int                       pending_count;

   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int cycle_count = 0;

   fractional_baud_divider_search dut (.*);

   fbd_checker u_checker (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: random stall, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served < hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left <= LongHold;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   task automatic send_rate_query(input logic [ClockWidth-1:0] clk_hz,
                                  input logic [BaudWidth-1:0] baud);
      bit taken;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_clock_hz <= clk_hz;
      req_wanted_baud <= baud;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   // drop valid and hold until every expected result has come
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      @(posedge clock);
   endtask

   task automatic send_random_query();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70)
         send_rate_query(ClockWidth'($urandom_range(200000000, 1000000)),
                         BaudWidth'($urandom_range(4000000, 300)));
      else if (pick < 80)
         send_rate_query(ClockWidth'($urandom_range(200000000, 1)),
                         BaudWidth'($urandom_range(20000, 1)));
      else if (pick < 95)
         send_rate_query(ClockWidth'($urandom()), BaudWidth'($urandom()));
      else
         send_rate_query(ClockWidth'($urandom()), '0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, zero inputs, exact match, smallest divisor
      send_rate_query('0, '0);
      send_rate_query('0, 22'd9600);
      send_rate_query(28'd12000000, '0);
      send_rate_query(28'd1, 22'd1);
      send_rate_query('1, 22'd1);
      send_rate_query('1, '1);
      send_rate_query(28'd6400, 22'd100);
      send_rate_query(28'd14745600, 22'd115200);
      send_rate_query(28'd12000000, 22'd9600);
      send_rate_query(28'd25000000, 22'd115200);
      send_rate_query(28'd48000000, 22'd4000000);
      send_rate_query(28'd200000000, 22'd4000000);
      send_rate_query(28'd200000000, 22'd300);
      send_rate_query(28'd1000, 22'd4000000);
      send_rate_query(28'h5555555, 22'h2AAAAA);
      send_rate_query(28'hAAAAAAA, 22'h155555);
      drain();

      sender_idle_pct = 23;
      receiver_idle_pct = 85;
      for (int i = 0; i < 28; i++) begin
         if (i == 5) hold_requests = hold_requests + 1;
         send_random_query();
      end

      sender_idle_pct = 85;
      receiver_idle_pct = 23;
      for (int i = 0; i < 28; i++) send_random_query();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      for (int i = 0; i < 28; i++) send_random_query();

      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
